// ----- rtl/core/ddas_pkg.sv -----
// Shared types, constants and helpers for the decimal digit add/subtract block.
`timescale 1ns / 1ps
package ddas_pkg;

    // Decimal radix in the 5-bit digit arithmetic, and the largest decimal digit
    localparam logic [4:0] RADIX     = 5'd10;
    localparam logic [3:0] DIGIT_MAX = 4'd9;

    // What the datapath loads into the output register
    typedef enum logic [1:0] {
        PUT_DIGIT = 2'd0,
        PUT_ERR   = 2'd1,
        PUT_ZERO  = 2'd2,
        PUT_CARRY = 2'd3
    } put_kind_t;

    // Controller to datapath commands
    typedef struct packed {
        logic      load;       // input beat accepted: store pair, latch operation
        logic      scan_init;  // set up the carry or compare pass
        logic      scan_step;  // evaluate one digit pair of the pass
        logic      emit_init;  // rewind to the least significant digit
        logic      put;        // load the output register
        put_kind_t kind;
        logic      finish;     // run done: clear count and overflow flag
    } ddas_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic too_long;     // more pairs than the store holds
        logic op_sub;       // latched operation is subtract
        logic scan_end;     // pass address is on its final digit
        logic emit_end;     // emit address is on the most significant digit
        logic final_carry;  // carry out of the full-width sum
        logic equal;        // operands compare equal
        logic full;         // run filled every digit position
        logic out_free;     // output register can take a beat
    } ddas_status_t;

    // Clamp a raw 4-bit field to a decimal digit
    function automatic logic [3:0] sat_digit(input logic [3:0] d);
        sat_digit = (d > DIGIT_MAX) ? DIGIT_MAX : d;
    endfunction

endpackage

// ----- rtl/core/ddas_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module ddas_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 40
) (
    input  logic                                          clk,
    input  logic                                          we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                              wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                              rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/core/ddas_ctrl.sv -----
// Sequencer: load, carry/compare pass, digit emit and special result beats.
`timescale 1ns / 1ps
module ddas_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  last,
    input  ddas_pkg::ddas_status_t st,
    output logic                  in_ready,
    output ddas_pkg::ddas_cmd_t   cmd
);
    typedef enum logic [9:0] {
        ST_LOAD      = 10'b0000000001,
        ST_PREP      = 10'b0000000010,
        ST_SCAN_RD   = 10'b0000000100,
        ST_SCAN_EV   = 10'b0000001000,
        ST_EMIT_INIT = 10'b0000010000,
        ST_EMIT_RD   = 10'b0000100000,
        ST_EMIT_PUT  = 10'b0001000000,
        ST_PUT_ERR   = 10'b0010000000,
        ST_PUT_ZERO  = 10'b0100000000,
        ST_PUT_CARRY = 10'b1000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == ST_LOAD);

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.kind   = ddas_pkg::PUT_DIGIT;
        case (state_reg)
            ST_LOAD:
            begin
                cmd.load = in_valid;
                if (in_valid && last)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                cmd.scan_init = 1'b1;
                state_next    = st.too_long ? ST_PUT_ERR : ST_SCAN_RD;
            end
            ST_SCAN_RD:
            begin
                state_next = ST_SCAN_EV;
            end
            ST_SCAN_EV:
            begin
                cmd.scan_step = 1'b1;
                state_next    = st.scan_end ? ST_EMIT_INIT : ST_SCAN_RD;
            end
            ST_EMIT_INIT:
            begin
                cmd.emit_init = 1'b1;
                if (!st.op_sub && st.final_carry && st.full)
                begin
                    state_next = ST_PUT_ERR;
                end
                else if (st.op_sub && st.equal)
                begin
                    state_next = ST_PUT_ZERO;
                end
                else
                begin
                    state_next = ST_EMIT_RD;
                end
            end
            ST_EMIT_RD:
            begin
                state_next = ST_EMIT_PUT;
            end
            ST_EMIT_PUT:
            begin
                if (st.out_free)
                begin
                    cmd.put = 1'b1;
                    if (!st.emit_end)
                    begin
                        state_next = ST_EMIT_RD;
                    end
                    else if (!st.op_sub && st.final_carry)
                    begin
                        state_next = ST_PUT_CARRY;
                    end
                    else
                    begin
                        cmd.finish = 1'b1;
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_PUT_ERR, ST_PUT_ZERO, ST_PUT_CARRY:
            begin
                if (state_reg == ST_PUT_ERR)
                begin
                    cmd.kind = ddas_pkg::PUT_ERR;
                end
                else if (state_reg == ST_PUT_ZERO)
                begin
                    cmd.kind = ddas_pkg::PUT_ZERO;
                end
                else
                begin
                    cmd.kind = ddas_pkg::PUT_CARRY;
                end
                if (st.out_free)
                begin
                    cmd.put    = 1'b1;
                    cmd.finish = 1'b1;
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // A finishing beat always returns the sequencer to loading
    a_finish_to_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> state_reg == ST_LOAD)
        else $error("run finished but sequencer did not return to load");

endmodule

// ----- rtl/core/ddas_datapath.sv -----
// Digit store, count, carry/borrow chain and output register.
`timescale 1ns / 1ps
module ddas_datapath #(
    parameter int MAX_DIGITS = 40
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  ddas_pkg::ddas_cmd_t    cmd,
    output ddas_pkg::ddas_status_t st,
    input  logic                   operation,
    input  logic [3:0]             digit_x,
    input  logic [3:0]             digit_y,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [3:0]             digit,
    output logic                   negative,
    output logic                   status,
    output logic                   last_digit
);
    localparam int AW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int CW = $clog2(MAX_DIGITS + 1);
    localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_DIGITS);

    logic [CW-1:0] count_reg, count_next;
    logic          too_long_reg, too_long_next;
    logic          op_reg;
    logic [AW-1:0] addr_reg;
    logic          carry_reg;   // pass result: add carry chain
    logic          eq_reg;      // pass result: no differing pair seen yet
    logic          neg_reg;     // pass result: y larger than x
    logic          chain_reg;   // emit carry or borrow
    logic          out_valid_reg;
    logic [3:0]    digit_reg;
    logic          negative_reg;
    logic          status_reg;
    logic          last_digit_reg;

    logic          we;
    logic [7:0]    rdata;
    logic [3:0]    rx, ry;
    logic [CW-1:0] count_m1;
    logic [AW-1:0] top_addr;
    logic [4:0]    scan_sum;
    logic [4:0]    add_sum;
    logic [3:0]    add_digit;
    logic          add_carry;
    logic [3:0]    big, sml;
    logic [4:0]    sub_diff;
    logic [3:0]    sub_digit;
    logic          sub_borrow;
    logic          out_free;

    // Operand store: x in the high nibble, y in the low nibble
    assign we = cmd.load && (count_reg < COUNT_MAX);

    ddas_ram #(
        .WIDTH(8),
        .DEPTH(MAX_DIGITS)
    ) u_store (
        .clk  (clk),
        .we   (we),
        .waddr(count_reg[AW-1:0]),
        .wdata({ddas_pkg::sat_digit(digit_x), ddas_pkg::sat_digit(digit_y)}),
        .raddr(addr_reg),
        .rdata(rdata)
    );

    assign rx       = rdata[7:4];
    assign ry       = rdata[3:0];
    assign count_m1 = count_reg - CW'(1);
    assign top_addr = count_m1[AW-1:0];

    // Carry pass over one pair
    assign scan_sum = {1'b0, rx} + {1'b0, ry} + {4'b0, carry_reg};

    // Emit: decimal add digit
    assign add_sum   = {1'b0, rx} + {1'b0, ry} + {4'b0, chain_reg};
    assign add_carry = (add_sum >= ddas_pkg::RADIX);
    assign add_digit = add_carry ? 4'(add_sum - ddas_pkg::RADIX) : add_sum[3:0];

    // Emit: decimal subtract of the smaller operand from the larger
    assign big        = neg_reg ? ry : rx;
    assign sml        = neg_reg ? rx : ry;
    assign sub_diff   = ({1'b0, big} + ddas_pkg::RADIX) - ({1'b0, sml} + {4'b0, chain_reg});
    assign sub_borrow = (sub_diff < ddas_pkg::RADIX);
    assign sub_digit  = sub_borrow ? sub_diff[3:0] : 4'(sub_diff - ddas_pkg::RADIX);

    assign out_free = !out_valid_reg || out_ready;

    // Status to the sequencer
    always_comb
    begin
        st.too_long    = too_long_reg;
        st.op_sub      = op_reg;
        st.scan_end    = op_reg ? (addr_reg == '0) : (addr_reg == top_addr);
        st.emit_end    = (addr_reg == top_addr);
        st.final_carry = carry_reg;
        st.equal       = eq_reg;
        st.full        = (count_reg == COUNT_MAX);
        st.out_free    = out_free;
    end

    // Digit count and overflow flag
    always_comb
    begin
        count_next    = count_reg;
        too_long_next = too_long_reg;
        if (cmd.finish)
        begin
            count_next    = '0;
            too_long_next = 1'b0;
        end
        else if (cmd.load)
        begin
            if (we)
            begin
                count_next = count_reg + CW'(1);
            end
            else
            begin
                too_long_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            too_long_reg <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            too_long_reg <= too_long_next;
        end
    end

    // Pass address, chain bits and compare result
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= operation;
        end
        if (cmd.scan_init)
        begin
            addr_reg  <= op_reg ? top_addr : '0;
            carry_reg <= 1'b0;
            eq_reg    <= 1'b1;
            neg_reg   <= 1'b0;
        end
        else if (cmd.scan_step)
        begin
            if (op_reg)
            begin
                addr_reg <= addr_reg - AW'(1);
                if (eq_reg && (rx != ry))
                begin
                    eq_reg  <= 1'b0;
                    neg_reg <= (rx < ry);
                end
            end
            else
            begin
                addr_reg  <= addr_reg + AW'(1);
                carry_reg <= (scan_sum >= ddas_pkg::RADIX);
            end
        end
        else if (cmd.emit_init)
        begin
            addr_reg  <= '0;
            chain_reg <= 1'b0;
        end
        else if (cmd.put && (cmd.kind == ddas_pkg::PUT_DIGIT))
        begin
            addr_reg  <= addr_reg + AW'(1);
            chain_reg <= op_reg ? sub_borrow : add_carry;
        end
    end

    // Output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.put)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (cmd.put)
        begin
            case (cmd.kind)
                ddas_pkg::PUT_DIGIT:
                begin
                    digit_reg      <= op_reg ? sub_digit : add_digit;
                    negative_reg   <= op_reg && neg_reg;
                    status_reg     <= 1'b0;
                    last_digit_reg <= st.emit_end && (op_reg || !carry_reg);
                end
                ddas_pkg::PUT_ERR:
                begin
                    digit_reg      <= 4'd0;
                    negative_reg   <= 1'b0;
                    status_reg     <= 1'b1;
                    last_digit_reg <= 1'b1;
                end
                ddas_pkg::PUT_ZERO:
                begin
                    digit_reg      <= 4'd0;
                    negative_reg   <= 1'b0;
                    status_reg     <= 1'b0;
                    last_digit_reg <= 1'b1;
                end
                ddas_pkg::PUT_CARRY:
                begin
                    digit_reg      <= 4'd1;
                    negative_reg   <= 1'b0;
                    status_reg     <= 1'b0;
                    last_digit_reg <= 1'b1;
                end
                default:
                begin
                    digit_reg      <= 4'd0;
                    negative_reg   <= 1'b0;
                    status_reg     <= 1'b1;
                    last_digit_reg <= 1'b1;
                end
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign digit      = digit_reg;
    assign negative   = negative_reg;
    assign status     = status_reg;
    assign last_digit = last_digit_reg;

    // Count never runs past the store
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_MAX)
        else $error("digit count past store depth");

    // Overflow flag only with a full store
    a_too_long_full: assert property (@(posedge clk) disable iff (!rst_n)
        too_long_reg |-> count_reg == COUNT_MAX)
        else $error("too-long flag set with store not full");

    // An error beat is a lone zero that closes the run
    a_error_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg) |-> (digit_reg == 4'd0 && !negative_reg && last_digit_reg))
        else $error("malformed error beat");

endmodule

// ----- rtl/core/decimal_digit_add_subtract.sv -----
// Top level of the multi-digit decimal adder/subtractor.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+--------------------------------------
//  in      | in        | in_valid / in_ready  | operation, digit_x, digit_y, last
//  out     | out       | out_valid / out_ready| digit, negative, status, last_digit
//
// Digit pairs load one per cycle into a MAX_DIGITS x 8 RAM with registered read.
// After the last beat of an n-digit run: a setup state, a carry or compare pass that
// reads and then evaluates each digit pair, a rewind, then a read and a put state per
// result digit (one more beat for a final add carry); the registered RAM read sets this pace.
// Output stalls hold the sequencer in place; no input is taken until the run ends.
// Reset clears the count, overflow flag, sequencer and output valid; RAM needs no clear.
`timescale 1ns / 1ps
module decimal_digit_add_subtract #(
    parameter int MAX_DIGITS = 40
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       operation,
    input  logic [3:0] digit_x,
    input  logic [3:0] digit_y,
    input  logic       last,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [3:0] digit,
    output logic       negative,
    output logic       status,
    output logic       last_digit
);
    ddas_pkg::ddas_cmd_t    cmd;
    ddas_pkg::ddas_status_t st;

    ddas_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .last    (last),
        .st      (st),
        .in_ready(in_ready),
        .cmd     (cmd)
    );

    ddas_datapath #(
        .MAX_DIGITS(MAX_DIGITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .st        (st),
        .operation (operation),
        .digit_x   (digit_x),
        .digit_y   (digit_y),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .digit     (digit),
        .negative  (negative),
        .status    (status),
        .last_digit(last_digit)
    );

endmodule

// ----- test/tb_top.sv -----
// Testbench for the decimal digit add/subtract block: predictor, stimulus and checks.
`timescale 1ns / 1ps
module tb_top;

    localparam int MAX_DIGITS  = 40;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 200;
    localparam int CYCLE_LIMIT = 300000;
    localparam int MAX_PRINTS  = 50;

    // Operation and status codes as seen on the ports
    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_SUB   = 1'b1;
    localparam logic ST_OK    = 1'b0;
    localparam logic ST_ERROR = 1'b1;

    // How send_run fills the digit pairs of one number
    typedef enum logic [1:0] {
        RUN_RANDOM,
        RUN_CLOSE,
        RUN_EQUAL,
        RUN_NINES
    } run_kind_t;

    typedef struct packed {
        logic [3:0] digit;
        logic       negative;
        logic       status;
        logic       last_digit;
    } result_beat_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic       operation = OP_ADD;
    logic [3:0] digit_x = 4'd0;
    logic [3:0] digit_y = 4'd0;
    logic       last = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [3:0] digit;
    logic       negative;
    logic       status;
    logic       last_digit;

    // Predictor state: stored operand digits, count and too-long flag
    logic [3:0]   held_x [MAX_DIGITS];
    logic [3:0]   held_y [MAX_DIGITS];
    int           held_count = 0;
    bit           held_overflow = 1'b0;
    result_beat_t pending_digits [$];

    // Run control
    bit tx_gaps = 1'b1;
    bit rx_gaps = 1'b1;
    bit hold_req = 1'b0;
    bit holding = 1'b0;

    int mismatches = 0;
    int pairs_sent = 0;
    int runs_sent = 0;
    int digits_checked = 0;
    int cycle_count = 0;

    decimal_digit_add_subtract #(
        .MAX_DIGITS(MAX_DIGITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operation (operation),
        .digit_x   (digit_x),
        .digit_y   (digit_y),
        .last      (last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .digit     (digit),
        .negative  (negative),
        .status    (status),
        .last_digit(last_digit)
    );

    // Clock, 10 ns period
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run time limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d digits still pending",
                     cycle_count, pending_digits.size());
            $display("decimal_digit_add_subtract test failed");
            $finish;
        end
    end

    function automatic logic [3:0] clamp_digit(input logic [3:0] d);
        return (d > ddas_pkg::DIGIT_MAX) ? ddas_pkg::DIGIT_MAX : d;
    endfunction

    function automatic void push_digit(input int d, input logic neg, input logic st,
                                       input logic fin);
        result_beat_t beat;
        beat.digit      = d[3:0];
        beat.negative   = neg;
        beat.status     = st;
        beat.last_digit = fin;
        pending_digits.push_back(beat);
    endfunction

    // Decimal sum or difference of the stored operands, pushed digit by digit
    function automatic void predict_pair(input logic op, input logic [3:0] dx,
                                         input logic [3:0] dy, input logic fin);
        int   sum_d [MAX_DIGITS];
        int   n;
        int   i;
        int   t;
        int   carry;
        int   borrow;
        int   cmp;
        int   big_d;
        int   small_d;
        logic neg;

        if (held_count < MAX_DIGITS)
        begin
            held_x[held_count] = clamp_digit(dx);
            held_y[held_count] = clamp_digit(dy);
            held_count++;
        end
        else
            held_overflow = 1'b1;

        if (fin)
        begin
            n = held_count;
            if (held_overflow)
                push_digit(0, 1'b0, ST_ERROR, 1'b1);
            else if (op == OP_ADD)
            begin
                carry = 0;
                for (i = 0; i < n; i++)
                begin
                    t = int'(held_x[i]) + int'(held_y[i]) + carry;
                    carry = (t >= int'(ddas_pkg::RADIX)) ? 1 : 0;
                    sum_d[i] = t - int'(ddas_pkg::RADIX) * carry;
                end
                // carry out of a full-width sum does not fit
                if (carry != 0 && n >= MAX_DIGITS)
                    push_digit(0, 1'b0, ST_ERROR, 1'b1);
                else
                begin
                    for (i = 0; i < n; i++)
                        push_digit(sum_d[i], 1'b0, ST_OK, carry == 0 && i == n - 1);
                    if (carry != 0)
                        push_digit(1, 1'b0, ST_OK, 1'b1);
                end
            end
            else
            begin
                // compare from the most significant digit
                cmp = 0;
                for (i = n - 1; i >= 0; i--)
                begin
                    if (held_x[i] != held_y[i])
                    begin
                        cmp = (held_x[i] > held_y[i]) ? 1 : -1;
                        break;
                    end
                end
                if (cmp == 0)
                    push_digit(0, 1'b0, ST_OK, 1'b1);
                else
                begin
                    neg = (cmp < 0);
                    borrow = 0;
                    for (i = 0; i < n; i++)
                    begin
                        big_d   = neg ? int'(held_y[i]) : int'(held_x[i]);
                        small_d = neg ? int'(held_x[i]) : int'(held_y[i]);
                        t = big_d + int'(ddas_pkg::RADIX) - (small_d + borrow);
                        if (t >= int'(ddas_pkg::RADIX))
                        begin
                            t -= int'(ddas_pkg::RADIX);
                            borrow = 0;
                        end
                        else
                            borrow = 1;
                        push_digit(t, neg, ST_OK, i == n - 1);
                    end
                end
            end
            held_count    = 0;
            held_overflow = 1'b0;
        end
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    // Compare one output beat with the oldest pending digit
    task automatic check_result();
        result_beat_t want;
        if (pending_digits.size() == 0)
            report_mismatch("unexpected output beat, digit", digit, 0);
        else
        begin
            want = pending_digits.pop_front();
            digits_checked++;
            if (digit !== want.digit)
                report_mismatch("digit", digit, want.digit);
            if (negative !== want.negative)
                report_mismatch("negative", negative, want.negative);
            if (status !== want.status)
                report_mismatch("status", status, want.status);
            if (last_digit !== want.last_digit)
                report_mismatch("last_digit", last_digit, want.last_digit);
        end
    endtask

    // Output side: check accepted beats, pick ready for the next cycle
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            check_result();
        out_ready <= !holding && !(rx_gaps && $urandom_range(0, 99) < 10);
    end

    // Long output stall, counted here so the sender keeps going meanwhile
    initial
    begin
        forever
        begin
            wait (hold_req);
            hold_req = 1'b0;
            holding <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            holding <= 1'b0;
        end
    end

    // Offer one digit pair and wait for the beat to be taken
    task automatic send_pair(input logic op, input logic [3:0] dx, input logic [3:0] dy,
                             input logic fin);
        if (tx_gaps)
        begin
            while ($urandom_range(0, 99) < 10)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid  <= 1'b1;
        operation <= op;
        digit_x   <= dx;
        digit_y   <= dy;
        last      <= fin;
        do
            @(posedge clk);
        while (!in_ready);
        pairs_sent++;
        if (fin)
            runs_sent++;
        predict_pair(op, dx, dy, fin);
    endtask

    // Drop valid and wait until every pending digit has come out
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_digits.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [3:0] rand_digit();
        logic [3:0] d;
        if ($urandom_range(0, 9) == 0)
            d = $urandom_range(10, 15);
        else
            d = $urandom_range(0, 9);
        return d;
    endfunction

    // One number of len digit pairs; op on the final beat decides
    task automatic send_run(input int len, input logic op, input run_kind_t kind);
        int         i;
        logic [3:0] dx;
        logic [3:0] dy;
        logic       beat_op;
        for (i = 0; i < len; i++)
        begin
            case (kind)
                RUN_NINES:
                begin
                    dx = ddas_pkg::DIGIT_MAX;
                    dy = ddas_pkg::DIGIT_MAX;
                end
                RUN_EQUAL:
                begin
                    dx = rand_digit();
                    dy = dx;
                end
                RUN_CLOSE:
                begin
                    dx = rand_digit();
                    dy = (i == 0) ? rand_digit() : dx;
                end
                default:
                begin
                    dx = rand_digit();
                    dy = rand_digit();
                end
            endcase
            beat_op = (i == len - 1) ? op : logic'($urandom_range(0, 1));
            send_pair(beat_op, dx, dy, i == len - 1);
        end
    endtask

    // Single and few-digit numbers at the edges of the digit range
    task automatic test_corner_digits();
        send_pair(OP_ADD, 4'd0, 4'd0, 1'b1);
        send_pair(OP_ADD, 4'd9, 4'd9, 1'b1);
        send_pair(OP_SUB, 4'd5, 4'd5, 1'b1);
        send_pair(OP_SUB, 4'd3, 4'd7, 1'b1);
        send_pair(OP_SUB, 4'd9, 4'd0, 1'b1);
        // fields above nine clamp to nine
        send_pair(OP_ADD, 4'd15, 4'd10, 1'b1);
        send_pair(OP_SUB, 4'd12, 4'd9, 1'b1);
        // 100 - 1: borrow ripples, operation only counts on the final beat
        send_pair(OP_ADD, 4'd0, 4'd1, 1'b0);
        send_pair(OP_ADD, 4'd0, 4'd0, 1'b0);
        send_pair(OP_SUB, 4'd1, 4'd0, 1'b1);
        // 1 - 100 comes out negative
        send_pair(OP_SUB, 4'd1, 4'd0, 1'b0);
        send_pair(OP_ADD, 4'd0, 4'd0, 1'b0);
        send_pair(OP_SUB, 4'd0, 4'd1, 1'b1);
        // equal two-digit operands
        send_pair(OP_ADD, 4'd7, 4'd7, 1'b0);
        send_pair(OP_SUB, 4'd3, 4'd3, 1'b1);
        wait_drained();
    endtask

    // Full store with a sum that overflows, and operands one digit too long
    task automatic test_length_limits();
        send_run(MAX_DIGITS, OP_ADD, RUN_NINES);
        send_run(MAX_DIGITS + 1, OP_ADD, RUN_RANDOM);
        send_run(1, OP_SUB, RUN_RANDOM);
        wait_drained();
    endtask

    // Random short numbers, with idle gaps on both sides
    task automatic test_random_runs(input int pairs);
        int        sent;
        int        len;
        int        pick;
        run_kind_t kind;
        sent = 0;
        while (sent < pairs)
        begin
            len  = $urandom_range(1, 8);
            pick = $urandom_range(0, 99);
            if (pick < 70)
                kind = RUN_RANDOM;
            else if (pick < 82)
                kind = RUN_CLOSE;
            else if (pick < 92)
                kind = RUN_EQUAL;
            else
                kind = RUN_NINES;
            send_run(len, logic'($urandom_range(0, 1)), kind);
            sent += len;
            // sometimes let the block go fully idle before the next number
            if ($urandom_range(0, 9) == 0)
                wait_drained();
        end
        wait_drained();
    endtask

    // Back to back beats with no gaps on either side
    task automatic test_steady_stream();
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        test_random_runs(8);
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
    endtask

    // Output held off while several numbers are offered
    task automatic test_output_stall();
        hold_req = 1'b1;
        send_run(4, OP_ADD, RUN_NINES);
        send_run(3, OP_SUB, RUN_RANDOM);
        send_run(2, OP_SUB, RUN_CLOSE);
        wait_drained();
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_corner_digits();
        test_length_limits();
        test_random_runs(6);
        test_steady_stream();
        test_output_stall();

        // nothing more may come out after the last expected digit
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("covered %0d numbers in %0d digit pairs, %0d result digits checked",
                 runs_sent, pairs_sent, digits_checked);
        $display("adds, subtracts, carries, borrows, equal operands, overflow and"
                 , " over-long operands, with gaps and a long output stall");
        if (mismatches == 0)
            $display("decimal_digit_add_subtract test passed");
        else
            $display("decimal_digit_add_subtract test failed");
        $finish;
    end

endmodule
